// ===== rtl/prrd_pkg.sv =====
// Shared types and codes for the priority round-robin dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package prrd_pkg;

  localparam int PRI_W   = 4;
  localparam int REM_W   = 16;
  localparam int STAMP_W = 16;
  localparam int SLOT_W  = 5;
  localparam int QUANT_W = 8;
  localparam int TIME_W  = 32;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] ST_ADDED      = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_NONE       = 2'd3;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

  typedef struct packed {
    logic             opcode;
    logic [PRI_W-1:0] priority_req;
    logic [REM_W-1:0] burst;
  } task_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [REM_W-1:0]  slice_length;
    logic              finished;
    logic [TIME_W-1:0] end_time;
  } result_t;

  // one table entry as kept in the task memory
  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [REM_W-1:0]   rem;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // candidate seen by the selection unit; age = next_stamp - stamp
  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [STAMP_W-1:0] age;
    logic [REM_W-1:0]   rem;
  } cand_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_DISP_SCAN,
    S_DISP_DRAIN,
    S_DISP_EXEC,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/prrd_pick.sv =====
// Running best-candidate tracker: one priority/age compare per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prrd_pick #(
  parameter int IDX_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              cand_en,
  input  wire prrd_pkg::cand_t   cand,
  input  wire logic [IDX_W-1:0]  cand_idx,
  output logic                   found,
  output prrd_pkg::cand_t        best,
  output logic [IDX_W-1:0]       best_idx
);
  import prrd_pkg::*;

  logic take;

  // higher priority wins; among equals the larger age (waited longest)
  assign take = cand_en &&
                (!found || (cand.pri > best.pri) ||
                 ((cand.pri == best.pri) && (cand.age > best.age)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= cand;
      best_idx <= cand_idx;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/priority_round_robin_dispatcher.sv =====
// Top level of the priority round-robin task dispatcher.
//
// Task channel (task_valid/task_stall/task_item): opcode 0 adds a task with
// priority_req and burst; opcode 1 dispatches one time slice. One result per
// item comes out on the result channel (result_valid/result_stall/result).
// quantum_valid/quantum_ready/quantum_data writes the slice quantum (reset 10,
// zero acts as 1); quantum_ready is always high.
// Flow: an add walks the valid bits from slot 0 up to the lowest free slot, then
// passes its result through S_PUSH to the output register before the next item
// can be taken. A full table skips the scan and goes straight to S_PUSH.
// A dispatch scans every slot through the task memory, one read and one compare
// per cycle, then drains, executes and pushes before the next item is taken.
// One item is in flight at a time; task_stall is high while it is worked on.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, the block holds its next result until the
// output register frees up.
// Reset clears the valid bits, counters and elapsed time and sets the quantum to 10;
// the task memory needs no clearing since unused slots are read but never taken as candidates.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_dispatcher #(
  parameter int MAX_TASKS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 task_valid,
  output logic                      task_stall,
  input  wire prrd_pkg::task_item_t task_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output prrd_pkg::result_t         result,
  input  wire logic                 quantum_valid,
  output logic                      quantum_ready,
  input  wire logic [7:0]           quantum_data
);
  import prrd_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]     idx;
  task_item_t           item;
  logic [MAX_TASKS-1:0] entry_valid;
  entry_t               mem [MAX_TASKS];
  entry_t               mem_q;
  logic                 rd_go;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [STAMP_W-1:0]   next_stamp;
  logic [CNT_W-1:0]     live_count;
  logic [TIME_W-1:0]    elapsed;
  logic [QUANT_W-1:0]   quantum;
  result_t              res, res_next;

  logic                 accept, res_load, out_load, do_add, do_disp;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  logic                 found;
  cand_t                cand, best;
  logic [IDX_W-1:0]     best_idx;

  logic [QUANT_W-1:0]   q_eff;
  logic                 use_rem;
  logic [REM_W-1:0]     slice, rem_new;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    elapsed_new;
  logic                 retire;

  assign quantum_ready = 1'b1;
  assign accept        = task_valid && !task_stall;

  // slice arithmetic for the selected task
  assign q_eff       = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign use_rem     = (live_count <= CNT_W'(1)) || (best.rem < REM_W'(q_eff));
  assign slice       = use_rem ? best.rem : REM_W'(q_eff);
  assign rem_new     = best.rem - slice;
  assign sum         = {1'b0, elapsed} + (TIME_W + 1)'(slice);
  assign elapsed_new = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign retire      = (rem_new == '0);

  assign cand.pri = mem_q.pri;
  assign cand.age = next_stamp - mem_q.stamp;
  assign cand.rem = mem_q.rem;

  prrd_pick #(
    .IDX_W(IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept),
    .cand_en  (rd_go && rd_vld),
    .cand     (cand),
    .cand_idx (rd_idx),
    .found    (found),
    .best     (best),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    task_stall = 1'b1;
    res_load   = 1'b0;
    out_load   = 1'b0;
    do_add     = 1'b0;
    do_disp    = 1'b0;
    res_next   = '{status: ST_NONE, slot: '0, slice_length: '0, finished: 1'b0,
                   end_time: elapsed};
    case (state)
      S_IDLE: begin
        task_stall = 1'b0;
        if (task_valid) begin
          if (task_item.opcode == OP_DISPATCH) begin
            state_next = S_DISP_SCAN;
          end else if (live_count == CNT_W'(MAX_TASKS)) begin
            res_next.status = ST_FULL;
            res_load        = 1'b1;
            state_next      = S_PUSH;
          end else begin
            state_next = S_ADD_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (!entry_valid[idx]) begin
          do_add          = 1'b1;
          res_next.status = ST_ADDED;
          res_next.slot   = SLOT_W'(idx);
          res_load        = 1'b1;
          state_next      = S_PUSH;
        end
      end
      S_DISP_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_DISP_DRAIN;
        end
      end
      S_DISP_DRAIN: begin
        state_next = S_DISP_EXEC;
      end
      S_DISP_EXEC: begin
        res_load = 1'b1;
        if (found) begin
          do_disp               = 1'b1;
          res_next.status       = ST_DISPATCHED;
          res_next.slot         = SLOT_W'(best_idx);
          res_next.slice_length = slice;
          res_next.finished     = retire;
          res_next.end_time     = elapsed_new;
        end
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory write port: new task on add, updated remaining/stamp on dispatch
  always_comb begin
    mem_we    = do_add || do_disp;
    mem_waddr = do_add ? idx : best_idx;
    if (do_add) begin
      mem_wdata = '{pri: item.priority_req, rem: item.burst, stamp: next_stamp};
    end else begin
      mem_wdata = '{pri: best.pri, rem: rem_new, stamp: next_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= task_item;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (out_load) begin
      result <= res;
    end
    rd_idx <= idx;
    rd_vld <= entry_valid[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      rd_go        <= 1'b0;
      entry_valid  <= '0;
      next_stamp   <= '0;
      live_count   <= '0;
      elapsed      <= '0;
      quantum      <= QUANTUM_RESET;
      result_valid <= 1'b0;
    end else begin
      rd_go <= (state == S_DISP_SCAN);
      if (accept) begin
        idx <= '0;
      end else if ((state == S_ADD_SCAN || state == S_DISP_SCAN) && idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end
      if (do_add) begin
        entry_valid[idx] <= 1'b1;
        next_stamp       <= next_stamp + STAMP_W'(1);
        live_count       <= live_count + CNT_W'(1);
      end
      if (do_disp) begin
        elapsed <= elapsed_new;
        if (retire) begin
          entry_valid[best_idx] <= 1'b0;
          live_count            <= live_count - CNT_W'(1);
        end else begin
          next_stamp <= next_stamp + STAMP_W'(1);
        end
      end
      if (quantum_valid && quantum_ready) begin
        quantum <= quantum_data;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_live_count : assert property (@(posedge clk) disable iff (rst)
    32'(live_count) == $countones(entry_valid))
    else $error("live count out of step with valid bits");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    live_count <= CNT_W'(MAX_TASKS))
    else $error("live count above table size");

  a_pick_valid : assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP_EXEC && found) |-> entry_valid[best_idx])
    else $error("dispatch picked an empty slot");

  a_add_free : assert property (@(posedge clk) disable iff (rst)
    do_add |=> entry_valid[$past(idx)] && live_count == $past(live_count) + CNT_W'(1))
    else $error("add did not claim its slot");

endmodule

`default_nettype wire
